FILE: rtl/core/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg: shared constants for the stream pattern masker
// Register indexes, the mask character and the fixed widths of the
// configuration port.
// ----------------------------------------------------------------------------
package spm_pkg;

  // Configuration port geometry
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Pattern bytes held by the two pattern registers
  localparam int PATTERN_BYTES = 16;
  localparam int PLEN_W        = 5;

  // Byte written in place of a matched pattern byte
  localparam logic [7:0] MASK_CHAR = 8'h2A;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

endpackage

FILE: rtl/core/spm_front.sv
// ----------------------------------------------------------------------------
// spm_front: window, pattern compare and burst descriptor builder
// Holds the configuration registers and the trailing-byte window. Each
// accepted byte is appended, compared against the pattern in parallel, and
// turned into at most one burst descriptor (bytes, beat count, final flag).
// ----------------------------------------------------------------------------
module spm_front #(
  parameter int MAX_PATTERN = 16,
  parameter int LEN_W       = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [spm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input beat
  input  logic                           accept,
  input  logic [7:0]                     in_byte,
  input  logic                           final_byte,
  // burst descriptor
  output logic                           cmd_valid,
  output logic [MAX_PATTERN*8-1:0]       cmd_bytes,
  output logic [LEN_W-1:0]               cmd_count,
  output logic                           cmd_fin
);
  import spm_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [PLEN_W-1:0]     pattern_length;

  logic [7:0]       win [MAX_PATTERN];
  logic [LEN_W-1:0] win_count;
  logic [LEN_W-1:0] win_count_next;

  logic [7:0]             aw  [MAX_PATTERN];
  logic [7:0]             pat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] byte_ok;
  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       cnt1;
  logic                   full;
  logic                   match;
  logic                   shift_win;

  // Configuration registers; a length write empties the window
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= PLEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as one, clamp to the window capacity
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  // Pattern bytes; positions past the two registers read as zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
    if (j < 8) begin : g_lo
      assign pat[j] = pattern_low[8*j +: 8];
    end else if (j < PATTERN_BYTES) begin : g_hi
      assign pat[j] = pattern_high[8*(j-8) +: 8];
    end else begin : g_zero
      assign pat[j] = 8'h00;
    end
  end

  // Window with the new byte appended, and per-position compare
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
    assign aw[j]      = (LEN_W'(j) == win_count) ? in_byte : win[j];
    assign byte_ok[j] = (LEN_W'(j) >= eff_len) || (aw[j] == pat[j]);
    assign cmd_bytes[8*j +: 8] = (full && match) ? MASK_CHAR : aw[j];
  end

  assign cnt1      = win_count + LEN_W'(1);
  assign full      = (cnt1 == eff_len);
  assign match     = &byte_ok;
  assign shift_win = full && !match && !final_byte;

  // Burst descriptor: mask run, oldest byte, or flush of the window
  always_comb begin
    cmd_valid = full || final_byte;
    cmd_fin   = final_byte;
    if (full) begin
      cmd_count = (match || final_byte) ? eff_len : LEN_W'(1);
    end else begin
      cmd_count = cnt1;
    end
    if (full) begin
      win_count_next = shift_win ? (eff_len - LEN_W'(1)) : '0;
    end else begin
      win_count_next = final_byte ? '0 : cnt1;
    end
  end

  // Window fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      win_count <= '0;
    end else if (cfg_write && cfg_index == REG_PATTERN_LEN) begin
      win_count <= '0;
    end else if (accept) begin
      win_count <= win_count_next;
    end
  end

  // Window bytes, slid by one when the oldest byte leaves
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_win
    if (j < MAX_PATTERN - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (accept) begin
          win[j] <= shift_win ? aw[j+1] : aw[j];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (accept) begin
          win[j] <= aw[j];
        end
      end
    end
  end

endmodule

FILE: rtl/core/spm_queue.sv
// ----------------------------------------------------------------------------
// spm_queue: two-entry descriptor queue
// Decouples the compare front from the output sequencer so either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module spm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  import spm_pkg::*;

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       level;
  logic             do_push;
  logic             do_pop;

  assign full     = (level == 2'd2);
  assign valid    = (level != 2'd0);
  assign pop_data = entry[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      level <= level + 2'(do_push) - 2'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/spm_back.sv
// ----------------------------------------------------------------------------
// spm_back: output sequencer
// Loads one burst descriptor at a time and plays its bytes out, one beat
// per cycle while out_stall is low, marking the last beat of the burst and the end of the stream.
// ----------------------------------------------------------------------------
module spm_back #(
  parameter int MAX_PATTERN = 16,
  parameter int LEN_W       = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  // descriptor queue head
  input  logic                     q_valid,
  input  logic [MAX_PATTERN*8-1:0] q_bytes,
  input  logic [LEN_W-1:0]         q_count,
  input  logic                     q_fin,
  output logic                     q_pop,
  // output beat
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_byte,
  output logic                     run_last,
  output logic                     stream_end
);
  import spm_pkg::*;

  logic [MAX_PATTERN*8-1:0] cur;
  logic [LEN_W-1:0]         rem;
  logic                     cur_fin;
  logic                     take;
  logic                     last_beat;

  assign out_valid  = (rem != '0);
  assign out_byte   = cur[7:0];
  assign last_beat  = (rem == LEN_W'(1));
  assign run_last   = last_beat;
  assign stream_end = last_beat && cur_fin;
  assign take       = out_valid && !out_stall;
  // next burst enters as the current one drains
  assign q_pop      = q_valid && (!out_valid || (last_beat && take));

  // Beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (q_pop) begin
      rem <= q_count;
    end else if (take) begin
      rem <= rem - LEN_W'(1);
    end
  end

  // Burst bytes, oldest in the low byte
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_bytes;
      cur_fin <= q_fin;
    end else if (take) begin
      cur <= cur >> 8;
    end
  end

endmodule

FILE: rtl/core/stream_pattern_masker.sv
// ----------------------------------------------------------------------------
// stream_pattern_masker: masks every occurrence of a byte pattern with '*'
// Byte stream in, byte stream out. Matching is leftmost, non-overlapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_byte, final_byte) are taken when in_valid is high and
//   in_stall is low. Output beats (out_byte, run_last, stream_end) are
//   taken when out_valid is high and out_stall is low.
//   Program pattern_low/high (index 0/1) and pattern_length (index 2) via
//   cfg_write/cfg_index/cfg_data while the block is idle; a length write
//   drops any bytes held in the window.
//   Each input beat yields zero or more output beats: none while the window
//   fills, one passed byte, L asterisks on a match, or a window flush when
//   final_byte is set. run_last marks the last of them, stream_end the last
//   beat of a final input.
//   Each descriptor is registered in the queue, then in the sequencer.
//   Throughput: one input beat per cycle while in_stall is low; output
//   bursts are absorbed by a two-entry queue.
//   A stalled receiver holds the current beat; input keeps flowing until
//   the queue fills, then in_stall rises.
//   Reset empties the window and queue; pattern is zero, length is one.
// ----------------------------------------------------------------------------
module stream_pattern_masker #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [spm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            final_byte,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            run_last,
  output logic                            stream_end
);
  import spm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CMD_W = MAX_PATTERN * 8 + LEN_W + 1;

  logic                     accept;
  logic                     cmd_valid;
  logic [MAX_PATTERN*8-1:0] cmd_bytes;
  logic [LEN_W-1:0]         cmd_count;
  logic                     cmd_fin;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;
  logic [CMD_W-1:0]         q_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  spm_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .cmd_valid  (cmd_valid),
    .cmd_bytes  (cmd_bytes),
    .cmd_count  (cmd_count),
    .cmd_fin    (cmd_fin)
  );

  spm_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && cmd_valid),
    .push_data ({cmd_fin, cmd_count, cmd_bytes}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  spm_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_bytes    (q_data[MAX_PATTERN*8-1:0]),
    .q_count    (q_data[MAX_PATTERN*8 +: LEN_W]),
    .q_fin      (q_data[CMD_W-1]),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule

FILE: rtl/core/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker: port-level checks for the stream pattern masker
// Watches the top-level ports only and is bound onto the top level.
// ----------------------------------------------------------------------------
module spm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_end
);
  import spm_pkg::*;

  // Reset leaves no output beat pending
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present right after reset");

  // Reset leaves the queue empty, so input is open
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // End of stream only on the last beat of a burst
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_end) |-> run_last)
    else $error("stream_end without run_last");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(run_last) && $stable(stream_end)))
    else $error("stalled output beat changed");

endmodule

bind stream_pattern_masker spm_checker u_spm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .stream_end (stream_end)
);

FILE: dv/stream_pattern_masker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_masker_test: self-checking bench for the pattern masker
// Drives byte streams through the masker under random input bursts and
// output stalls, predicts every output beat from a behavioral copy of the
// window logic, and compares each accepted beat field by field.
// ----------------------------------------------------------------------------
module stream_pattern_masker_test;
  import spm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 100;
  localparam int MAX_LEN      = 16;

  // index with no register behind it; writes must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } masked_beat_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD, STALL_TOGGLE} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_byte = 8'h00;
  logic                   final_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   run_last;
  logic                   stream_end;

  stream_pattern_masker i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .final_byte(final_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .stream_end(stream_end)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mirror of the block: pattern registers and trailing-byte window
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0]  pat_len = 5'd1;
  logic [7:0]  win [0:MAX_LEN-1];
  int          win_count = 0;

  masked_beat_t masked_q [$];
  int           mismatches = 0;
  int           cycles = 0;
  int           burst_left = 0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int active_length();
    int n;
    n = int'(pat_len);
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(input int i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  // Predict the output beats caused by one accepted input beat
  task automatic predict_masked(input logic [7:0] b, input logic fin);
    int         len;
    int         i;
    bit         hit;
    logic [7:0] emit [$];
    masked_beat_t bt;
    len = active_length();
    if (win_count >= len) win_count = 0;
    win[win_count] = b;
    win_count++;
    if (win_count == len) begin
      hit = 1'b1;
      for (i = 0; i < len; i++)
        if (win[i] != pattern_byte(i)) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < len; i++) emit.push_back(MASK_CHAR);
        win_count = 0;
      end else begin
        emit.push_back(win[0]);
        for (i = 0; i < len - 1; i++) win[i] = win[i+1];
        win_count = len - 1;
      end
    end
    // final beat flushes whatever the window still holds
    if (fin) begin
      for (i = 0; i < win_count; i++) emit.push_back(win[i]);
      win_count = 0;
    end
    for (i = 0; i < emit.size(); i++) begin
      bt.data       = emit[i];
      bt.run_last   = (i == emit.size() - 1);
      bt.stream_end = fin && (i == emit.size() - 1);
      masked_q.push_back(bt);
    end
  endtask

  // Send one beat, with a random gap at the start of each burst
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_byte    <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_masked(b, fin);
  endtask

  // Drop valid, wait for all expected beats plus pipeline drain
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (masked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the mirror follows at the same edge
  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:  pat_lo = val;
      REG_PATTERN_HIGH: pat_hi = val;
      REG_PATTERN_LEN: begin
        pat_len   = val[4:0];
        win_count = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Output checker
  always @(posedge clk) begin
    masked_beat_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (masked_q.size() == 0) begin
        report_error($sformatf("unexpected beat byte=%02h", out_byte));
      end else begin
        want = masked_q.pop_front();
        if (out_byte !== want.data)
          report_error($sformatf("out_byte %02h, want %02h", out_byte, want.data));
        if (run_last !== want.run_last)
          report_error($sformatf("run_last %b, want %b", run_last, want.run_last));
        if (stream_end !== want.stream_end)
          report_error($sformatf("stream_end %b, want %b", stream_end, want.stream_end));
      end
    end
  end

  // Receiver stall pattern: switches between several modes
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  logic        hold_val = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(10, 60);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HOLD: begin
        if (hold_left == 0) begin
          hold_val  = 1'($urandom_range(0, 1));
          hold_left = $urandom_range(1, 8);
        end
        hold_left--;
        out_stall <= hold_val;
      end
      default:      out_stall <= ~out_stall;
    endcase
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Reset values: length one, pattern zero, so 0x00 is masked
  task automatic test_reset_defaults();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
  endtask

  // "abc": slide out a leading byte, mask a match, flush a partial window
  task automatic test_match_and_slide();
    settle_idle();
    cfg_put(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
    cfg_put(REG_PATTERN_HIGH, 64'h0);
    cfg_put(REG_PATTERN_LEN, 64'd3);
    push_byte("x", 1'b0);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte("c", 1'b0);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte("a", 1'b1);
  endtask

  // A length of zero behaves as one
  task automatic test_length_zero();
    settle_idle();
    cfg_put(REG_PATTERN_LOW, 64'h0000_0000_0000_005A);
    cfg_put(REG_PATTERN_LEN, 64'd0);
    push_byte("Z", 1'b0);
    push_byte("q", 1'b1);
  endtask

  // Length above the maximum clamps to sixteen; all-ones pattern
  task automatic test_length_clamp();
    settle_idle();
    cfg_put(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_put(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_put(REG_PATTERN_LEN, 64'd31);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
  endtask

  // Length write while the window holds bytes drops them
  task automatic test_length_rewrite();
    settle_idle();
    cfg_put(REG_PATTERN_LOW, 64'h0000_0000_6463_6261);
    cfg_put(REG_PATTERN_HIGH, 64'h0);
    cfg_put(REG_PATTERN_LEN, 64'd4);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    settle_idle();
    cfg_put(REG_PATTERN_LEN, 64'd2);
    push_byte("b", 1'b1);
  endtask

  // Pattern write while the window holds bytes keeps them
  task automatic test_pattern_rewrite();
    settle_idle();
    cfg_put(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
    cfg_put(REG_PATTERN_LEN, 64'd3);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    settle_idle();
    cfg_put(REG_PATTERN_LOW, 64'h0000_0000_0064_6261);
    push_byte("d", 1'b1);
  endtask

  // Final beat on an empty window, plus a write to the unused index
  task automatic test_final_on_empty();
    settle_idle();
    cfg_put(REG_PATTERN_LEN, 64'd2);
    cfg_put(REG_UNUSED, {$urandom, $urandom});
    push_byte("k", 1'b1);
  endtask

  // Random streams: mostly pattern copies and near misses
  task automatic test_random_streams();
    int          sent;
    int          len;
    int          target;
    int          kind;
    int          cut;
    int          k;
    int          sel;
    logic [7:0]  alpha [0:2];
    logic [7:0]  pbytes [0:MAX_LEN-1];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len_w;
    logic [7:0]  stream_q [$];
    bit          fin;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        alpha[0] = "a";
        alpha[1] = "b";
        alpha[2] = MASK_CHAR;
      end else begin
        for (k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));
      end
      for (k = 0; k < MAX_LEN; k++)
        pbytes[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : alpha[$urandom_range(0, 2)];
      for (k = 0; k < 8; k++) begin
        lo[8*k +: 8] = pbytes[k];
        hi[8*k +: 8] = pbytes[k+8];
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0:       len_w = 5'd0;
        1:       len_w = 5'($urandom_range(17, 31));
        2:       len_w = 5'd16;
        default: len_w = 5'($urandom_range(1, 4));
      endcase

      settle_idle();
      cfg_put(REG_PATTERN_LOW, lo);
      cfg_put(REG_PATTERN_HIGH, hi);
      if ($urandom_range(0, 9) < 7) cfg_put(REG_PATTERN_LEN, {59'd0, len_w});

      len = active_length();
      target = $urandom_range(1, 2 * len + 6);
      stream_q.delete();
      while (stream_q.size() < target) begin
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
          for (k = 0; k < len; k++) stream_q.push_back(pattern_byte(k));
        end else if (kind < 12) begin
          cut = $urandom_range(0, len - 1);
          for (k = 0; k < cut; k++) stream_q.push_back(pattern_byte(k));
          stream_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 17) begin
          stream_q.push_back(alpha[$urandom_range(0, 2)]);
        end else begin
          stream_q.push_back(8'($urandom_range(0, 255)));
        end
      end

      for (k = 0; k < stream_q.size(); k++) begin
        fin = (k == stream_q.size() - 1) && ($urandom_range(0, 6) != 0);
        // an occasional stray final inside the stream
        if ($urandom_range(0, 29) == 0) fin = 1'b1;
        push_byte(stream_q[k], fin);
      end
      sent += stream_q.size();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_match_and_slide();
    test_length_zero();
    test_length_clamp();
    test_length_rewrite();
    test_pattern_rewrite();
    test_final_on_empty();
    test_random_streams();

    settle_idle();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && masked_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
